>>> hdl/gwp_pkg.sv
// Shared types and constants for the grid wavefront planner.
`timescale 1ns / 1ps
`default_nettype none
package gwp_pkg;

  localparam int DEF_MAX_WIDTH  = 32;
  localparam int DEF_MAX_HEIGHT = 32;
  localparam int DIM_W          = 9;
  localparam int DIST_W         = 11;

  localparam logic [DIST_W-1:0] SENTINEL = 11'd2047;

  localparam logic [1:0] KIND_NORMAL  = 2'd0;
  localparam logic [1:0] KIND_HAZARD  = 2'd1;
  localparam logic [1:0] KIND_DEADEND = 2'd2;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [2:0] DIR_NONE = 3'd0;
  localparam logic [2:0] DIR_PY   = 3'd1;
  localparam logic [2:0] DIR_PX   = 3'd2;
  localparam logic [2:0] DIR_NY   = 3'd3;
  localparam logic [2:0] DIR_NX   = 3'd4;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_WIPE, S_SEED, S_SEED_CHK, S_POP, S_CUR, S_CUR2,
    S_NB, S_EVAL, S_QCUR, S_QNB, S_QEVAL, S_QFIN
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    logic [2:0]        move;
    logic [DIST_W-1:0] distance;
  } result_t;

  function automatic logic [2:0] reverse_dir(input logic [2:0] d);
    case (d)
      DIR_PY:  reverse_dir = DIR_NY;
      DIR_PX:  reverse_dir = DIR_NX;
      DIR_NY:  reverse_dir = DIR_PY;
      DIR_NX:  reverse_dir = DIR_PX;
      default: reverse_dir = DIR_NONE;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> hdl/gwp_engine.sv
// Sequencer, map memories and wavefront queue of the grid planner.
`timescale 1ns / 1ps
`default_nettype none
module gwp_engine import gwp_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int XW    = $clog2(MAX_WIDTH),
  localparam int YW    = $clog2(MAX_HEIGHT)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [1:0]       mode,
  input  wire logic [XW-1:0]    x,
  input  wire logic [YW-1:0]    y,
  input  wire logic [1:0]       new_kind,
  input  wire logic [2:0]       prev_dir,
  input  wire logic             on_grid,
  input  wire logic [DIM_W-1:0] w_act,
  input  wire logic [DIM_W-1:0] h_act,
  output logic                  busy,
  output result_t               res
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam logic [AW:0] LAST = (AW+1)'(CELLS - 1);
  localparam logic [AW:0] FULL = (AW+1)'(CELLS);

  logic [1:0]        kind_mem [CELLS];
  logic [DIST_W-1:0] dist_mem [CELLS];
  logic [YW+XW-1:0]  q_mem    [CELLS];

  state_t state, state_next;

  logic [AW:0]       sweep, head, tail;
  logic [1:0]        mode_r, k;
  logic [2:0]        prev_r, move;
  logic              in_grid;
  logic [XW-1:0]     px, nbx;
  logic [YW-1:0]     py, nby;
  logic [DIST_W:0]   nd;
  logic [DIST_W-1:0] dist_c, best;

  logic [1:0]        kind_rd;
  logic [DIST_W-1:0] dist_rd;
  logic [YW+XW-1:0]  q_rd;

  logic [AW-1:0]     rd_addr, kind_wa, dist_wa;
  logic              kind_we, dist_we, q_we;
  logic [1:0]        kind_wd;
  logic [DIST_W-1:0] dist_wd;

  logic [2:0]        dir;
  logic              dir_ok;
  logic [XW-1:0]     dx;
  logic [YW-1:0]     dy;
  logic [DIST_W:0]   nd_c;
  logic              upd, allowed, take;

  function automatic logic [AW-1:0] addr_of(input logic [YW-1:0] yy, input logic [XW-1:0] xx);
    addr_of = AW'(yy * MAX_WIDTH) + AW'(xx);
  endfunction

  // neighbor under test
  always_comb begin
    if (state == S_QNB || state == S_QEVAL) begin
      dir = {1'b0, k} + 3'd1;
    end else begin
      case (k)
        2'd0:    dir = DIR_PX;
        2'd1:    dir = DIR_NX;
        2'd2:    dir = DIR_PY;
        default: dir = DIR_NY;
      endcase
    end
    dx = px;
    dy = py;
    dir_ok = 1'b0;
    case (dir)
      DIR_PY: begin
        dir_ok = (DIM_W'(py) + DIM_W'(1)) < h_act;
        dy = py + YW'(1);
      end
      DIR_PX: begin
        dir_ok = (DIM_W'(px) + DIM_W'(1)) < w_act;
        dx = px + XW'(1);
      end
      DIR_NY: begin
        dir_ok = (py != '0);
        dy = py - YW'(1);
      end
      default: begin
        dir_ok = (px != '0);
        dx = px - XW'(1);
      end
    endcase
    nd_c    = {1'b0, dist_rd} + (DIST_W+1)'(1);
    upd     = (kind_rd != KIND_HAZARD) && ({1'b0, dist_rd} > nd);
    allowed = (kind_rd != KIND_HAZARD) && (kind_rd != KIND_DEADEND) &&
              (nd_c >= {1'b0, dist_c});
    take    = allowed && ((move == DIR_NONE) || (dist_rd < best));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: if (sweep == LAST) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (mode == MODE_BUILD) state_next = S_WIPE;
          else if (mode == MODE_QUERY && on_grid) state_next = S_QCUR;
        end
      end
      S_WIPE: if (sweep == LAST) state_next = in_grid ? S_SEED : S_IDLE;
      S_SEED: state_next = S_SEED_CHK;
      S_SEED_CHK: state_next = (kind_rd == KIND_HAZARD) ? S_IDLE : S_POP;
      S_POP: state_next = (head == tail) ? S_IDLE : S_CUR;
      S_CUR: state_next = S_CUR2;
      S_CUR2: state_next = (nd_c >= {1'b0, SENTINEL}) ? S_POP : S_NB;
      S_NB: begin
        if (dir_ok) state_next = S_EVAL;
        else if (k == 2'd3) state_next = S_POP;
      end
      S_EVAL: state_next = (k == 2'd3) ? S_POP : S_NB;
      S_QCUR: state_next = S_QNB;
      S_QNB: begin
        if (dir_ok && prev_r != reverse_dir(dir)) state_next = S_QEVAL;
        else if (k == 2'd3) state_next = S_QFIN;
      end
      S_QEVAL: state_next = (k == 2'd3) ? S_QFIN : S_QNB;
      S_QFIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory control and result
  always_comb begin
    rd_addr = addr_of(py, px);
    kind_we = 1'b0;
    kind_wa = sweep[AW-1:0];
    kind_wd = KIND_NORMAL;
    dist_we = 1'b0;
    dist_wa = sweep[AW-1:0];
    dist_wd = SENTINEL;
    q_we    = 1'b0;
    res     = '0;
    case (state)
      S_INIT: begin
        kind_we = 1'b1;
        dist_we = 1'b1;
      end
      S_IDLE: begin
        rd_addr = addr_of(y, x);
        if (start) begin
          kind_we      = (mode == MODE_WRITE) && on_grid;
          kind_wa      = addr_of(y, x);
          kind_wd      = new_kind;
          res.valid    = (mode != MODE_BUILD) && !(mode == MODE_QUERY && on_grid);
          res.kind     = mode;
          res.distance = (mode == MODE_QUERY) ? SENTINEL : '0;
        end
      end
      S_WIPE: begin
        dist_we = 1'b1;
        if (sweep == LAST && !in_grid) begin
          res.valid    = 1'b1;
          res.kind     = MODE_BUILD;
          res.distance = SENTINEL;
        end
      end
      S_SEED: begin
        dist_we = 1'b1;
        dist_wa = addr_of(py, px);
        dist_wd = '0;
      end
      S_SEED_CHK: begin
        q_we      = (kind_rd != KIND_HAZARD);
        res.valid = (kind_rd == KIND_HAZARD);
        res.kind  = MODE_BUILD;
      end
      S_POP: begin
        res.valid = (head == tail);
        res.kind  = MODE_BUILD;
      end
      S_CUR: rd_addr = addr_of(q_rd[YW+XW-1:XW], q_rd[XW-1:0]);
      S_NB, S_QNB: rd_addr = addr_of(dy, dx);
      S_EVAL: begin
        dist_we = upd;
        dist_wa = addr_of(nby, nbx);
        dist_wd = nd[DIST_W-1:0];
        q_we    = upd && (tail < FULL);
      end
      S_QFIN: begin
        res.valid    = 1'b1;
        res.kind     = MODE_QUERY;
        res.move     = move;
        res.distance = dist_c;
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    kind_rd <= kind_mem[rd_addr];
    dist_rd <= dist_mem[rd_addr];
    q_rd    <= q_mem[head[AW-1:0]];
    if (kind_we) kind_mem[kind_wa] <= kind_wd;
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    if (q_we) q_mem[tail[AW-1:0]] <= (state == S_EVAL) ? {nby, nbx} : {py, px};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      sweep <= '0;
      head  <= '0;
      tail  <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_INIT, S_WIPE: sweep <= (sweep == LAST) ? '0 : sweep + (AW+1)'(1);
        S_IDLE: begin
          if (start) begin
            mode_r  <= mode;
            px      <= x;
            py      <= y;
            prev_r  <= prev_dir;
            in_grid <= on_grid;
            sweep   <= '0;
            head    <= '0;
            tail    <= '0;
            k       <= '0;
            move    <= DIR_NONE;
          end
        end
        S_SEED_CHK: if (kind_rd != KIND_HAZARD) tail <= tail + (AW+1)'(1);
        S_POP: if (head != tail) head <= head + (AW+1)'(1);
        S_CUR: begin
          px <= q_rd[XW-1:0];
          py <= q_rd[YW+XW-1:XW];
        end
        S_CUR2: begin
          nd <= nd_c;
          k  <= '0;
        end
        S_NB: begin
          if (dir_ok) begin
            nbx <= dx;
            nby <= dy;
          end else begin
            k <= k + 2'd1;
          end
        end
        S_EVAL: begin
          if (upd && tail < FULL) tail <= tail + (AW+1)'(1);
          k <= k + 2'd1;
        end
        S_QCUR: dist_c <= dist_rd;
        S_QNB: if (!(dir_ok && prev_r != reverse_dir(dir))) k <= k + 2'd1;
        S_QEVAL: begin
          if (take) begin
            best <= dist_rd;
            move <= dir;
          end
          k <= k + 2'd1;
        end
        default: ;
      endcase
    end
  end

  a_head_le_tail: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("queue head passed tail");
  a_tail_bound: assert property (@(posedge clk) disable iff (rst) tail <= FULL)
    else $error("queue overfilled");
  a_leave_done: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_INIT && state_next == S_IDLE) |-> res.valid)
    else $error("transaction ended without a result");
  a_query_mode: assert property (@(posedge clk) disable iff (rst)
    (state == S_QFIN) |-> (mode_r == MODE_QUERY && in_grid))
    else $error("query finish without a query transaction");
  a_build_mode: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEED) |-> (mode_r == MODE_BUILD && in_grid))
    else $error("seed without an in-grid build");

endmodule
`default_nettype wire

>>> hdl/grid_wavefront_planner_core.sv
// Top level of the grid wavefront planner: config registers and result register.
`timescale 1ns / 1ps
`default_nettype none
// A transaction is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done high, and the receiver cannot stall it.
// Cell writes, out-of-grid queries and mode 3 transactions finish in the cycle
// they are taken, with the result shown in the cycle after. A move query does
// one map read per neighbor on the single shared read port. A distance build
// first rewrites the whole distance memory, also when its target is off the
// grid, then pops each reached cell and reads and evaluates its neighbors one
// by one through the same read port.
// After reset the block clears both maps with busy high; configuration writes
// are taken throughout.
module grid_wavefront_planner_core import gwp_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode,
  input  wire logic [4:0]  cell_x,
  input  wire logic [4:0]  cell_y,
  input  wire logic [1:0]  new_kind,
  input  wire logic [2:0]  prev_dir,
  output logic             done,
  output logic [1:0]       result_kind,
  output logic [2:0]       move_dir,
  output logic [10:0]      cell_distance
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] MW = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MH = DIM_W'(MAX_HEIGHT);

  logic [5:0]       grid_width, grid_height;
  logic [DIM_W-1:0] w_act, h_act;
  logic             on_grid;
  result_t          res;

  always_comb begin
    if (grid_width == '0) w_act = DIM_W'(1);
    else if (DIM_W'(grid_width) > MW) w_act = MW;
    else w_act = DIM_W'(grid_width);
    if (grid_height == '0) h_act = DIM_W'(1);
    else if (DIM_W'(grid_height) > MH) h_act = MH;
    else h_act = DIM_W'(grid_height);
    on_grid = (DIM_W'(cell_x) < w_act) && (DIM_W'(cell_y) < h_act);
  end

  gwp_engine #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .mode    (mode),
    .x       (XW'(cell_x)),
    .y       (YW'(cell_y)),
    .new_kind(new_kind),
    .prev_dir(prev_dir),
    .on_grid (on_grid),
    .w_act   (w_act),
    .h_act   (h_act),
    .busy    (busy),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 6'd32;
      grid_height <= 6'd32;
      done        <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_WIDTH:  grid_width  <= cfg_data;
          CFG_HEIGHT: grid_height <= cfg_data;
          default: ;
        endcase
      end
      done <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      result_kind   <= res.kind;
      move_dir      <= res.move;
      cell_distance <= res.distance;
    end
  end

endmodule
`default_nettype wire
